// ===== rtl/core/inode_bitmap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator assertion macros
// Concurrent assertion shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INODE_BITMAP_ALLOCATOR_ASSERT_SVH
`define INODE_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define IBM_ASSERT_HOLD(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ibm_pkg.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator package
// Field widths, operation and status codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package ibm_pkg;

   localparam int unsigned MAX_GROUPS_DEF    = 16;
   localparam int unsigned MAX_PER_GROUP_DEF = 2048;

   localparam int unsigned IPG_W  = 12;
   localparam int unsigned GRP_W  = 5;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned NUM_W  = 16;
   localparam int unsigned HINT_W = 5;
   localparam int unsigned ST_W   = 2;

   localparam int unsigned CSR_AW = 1;
   localparam int unsigned CSR_DW = 12;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 24;
   localparam int unsigned REQ_NUM_LSB  = OP_W;
   localparam int unsigned REQ_HINT_LSB = OP_W + NUM_W;
   localparam int unsigned RSP_USE_BIT  = NUM_W;
   localparam int unsigned RSP_ST_LSB   = NUM_W + 1;
   localparam int unsigned RSP_PAD_W    = RSP_TDATA_W - NUM_W - 1 - ST_W;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned BIT_W  = 6;
   localparam int unsigned MAP_WORDS_DEF =
      (MAX_GROUPS_DEF * MAX_PER_GROUP_DEF + WORD_W - 1) / WORD_W;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   localparam logic [CSR_AW-1:0] REG_IPG = 1'b0;
   localparam logic [CSR_AW-1:0] REG_GRP = 1'b1;

   typedef struct packed {
      logic [NUM_W-1:0] alloc;
      logic             in_use;
      logic [ST_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } hit_type;

   // lowest set bit of a bitmap word
   function automatic hit_type find_first(input logic [WORD_W-1:0] v);
      hit_type h;
      h.found = |v;
      h.pos   = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            h.pos = BIT_W'(b);
         end
      end
      return h;
   endfunction

endpackage

// ===== rtl/core/ibm_ram.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ibm_ram import ibm_pkg::*; #(
   parameter int unsigned WIDTH = WORD_W,
   parameter int unsigned DEPTH = MAP_WORDS_DEF,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/inode_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator
// First-fit allocate, free and query over a grouped used/free inode bitmap.
// ----------------------------------------------------------------------------
// channel  direction  fields (lowest bit up)
// req      in         operation[1:0], inode_number[17:2], group_hint[22:18]
// rsp      out        allocated_number[15:0], in_use[16], status[18:17]
// csr      in         write only: index 0 inodes_per_group, 1 group_count
//
// One transaction at a time. After reset a clearing pass zeroes the bitmap RAM,
// one word per cycle (512 words at default size); req_tready stays low meanwhile.
// Allocate steps group by group from the hint, reading one bitmap word at a time
// through the single RAM read port. Free/query split the number by stepping over
// one group at a time, then read the word; free clears the bit. An unused op
// or bad number skips to the response. A stalled rsp holds the next result.
// ----------------------------------------------------------------------------
module inode_bitmap_allocator import ibm_pkg::*; #(
   parameter int unsigned MAX_GROUPS    = MAX_GROUPS_DEF,
   parameter int unsigned MAX_PER_GROUP = MAX_PER_GROUP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operation, inode_number, group_hint, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // allocated_number, in_use, status, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned TOTAL_BITS = MAX_GROUPS * MAX_PER_GROUP;
   localparam int unsigned MAP_WORDS  = (TOTAL_BITS + WORD_W - 1) / WORD_W;
   localparam int unsigned AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned FLW  = AW + BIT_W;
   localparam int unsigned GM_W = IPG_W + GRP_W;

   localparam logic [IPG_W-1:0] IPG_SAT = IPG_W'((MAX_PER_GROUP < (2**IPG_W - 1)) ?
                                                 MAX_PER_GROUP : (2**IPG_W - 1));
   localparam logic [GRP_W-1:0] GRP_SAT = GRP_W'((MAX_GROUPS < (2**GRP_W - 1)) ?
                                                 MAX_GROUPS : (2**GRP_W - 1));
   localparam logic [FLW-1:0] MPG_C    = FLW'(MAX_PER_GROUP);
   localparam logic [AW-1:0]  CLR_LAST = AW'(MAP_WORDS - 1);
   localparam logic [IPG_W-1:0] IPG_RST = IPG_W'(2048);
   localparam logic [GRP_W-1:0] GRP_RST = GRP_W'(16);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_GRP  = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_FIN  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_FADR = 4'd6;
   localparam logic [3:0] S_FMOD = 4'd7;
   localparam logic [3:0] S_RESP = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [IPG_W-1:0] ipg_ff;
   logic [GRP_W-1:0] grp_ff;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [GRP_W-1:0] gidx_ff, gidx_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [FLW-1:0]   gbase_ff, gbase_in;
   logic [FLW-1:0]   gend_ff, gend_in;
   logic [GM_W-1:0]  gmul_ff, gmul_in;
   logic [AW-1:0]    word_ff, word_in;
   logic [BIT_W-1:0] pos_ff, pos_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic [IPG_W-1:0]  ipg_eff;
   logic [GRP_W-1:0]  grp_eff;
   logic [GM_W-1:0]   total;
   logic [OP_W-1:0]   req_op;
   logic [NUM_W-1:0]  req_num;
   logic [HINT_W-1:0] req_hint;
   logic              req_fire;
   logic              range_bad;
   logic              out_free;
   logic [FLW-1:0]    base_c;
   logic [BIT_W-1:0]  lo_pos, hi_pos;
   logic [WORD_W-1:0] scan_mask;
   logic              last_word;
   hit_type           hit;
   logic [FLW-1:0]    flat_c;
   logic [FLW-1:0]    offs_c;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   ibm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ipg_eff   = (ipg_ff > IPG_SAT) ? IPG_SAT : ipg_ff;
   assign grp_eff   = (grp_ff > GRP_SAT) ? GRP_SAT : grp_ff;
   assign total     = GM_W'(ipg_eff) * GM_W'(grp_eff);
   assign req_op    = req_tdata[OP_W-1:0];
   assign req_num   = req_tdata[REQ_NUM_LSB +: NUM_W];
   assign req_hint  = req_tdata[REQ_HINT_LSB +: HINT_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign range_bad = (req_num == '0) || (GM_W'(req_num) > total) || (ipg_eff == '0);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign base_c    = FLW'(gidx_ff) * MPG_C;
   assign last_word = (word_ff == gend_ff[FLW-1:BIT_W]);
   assign lo_pos    = (word_ff == gbase_ff[FLW-1:BIT_W]) ? gbase_ff[BIT_W-1:0] : '0;
   assign hi_pos    = last_word ? gend_ff[BIT_W-1:0] : BIT_W'(WORD_W - 1);
   assign flat_c    = {word_ff, pos_ff};
   assign offs_c    = flat_c - gbase_ff;

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         scan_mask[b] = (BIT_W'(b) >= lo_pos) && (BIT_W'(b) <= hi_pos);
      end
   end

   assign hit = find_first(~ram_rdata & scan_mask);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      gidx_in   = gidx_ff;
      rem_in    = rem_ff;
      gbase_in  = gbase_ff;
      gend_in   = gend_ff;
      gmul_in   = gmul_ff;
      word_in   = word_ff;
      pos_in    = pos_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_waddr = word_ff;
      ram_wdata = ram_rdata;
      ram_raddr = word_ff;
      unique case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in  = req_op;
               res_in = '0;
               case (req_op) inside
                  OP_ALLOC: begin
                     gidx_in  = req_hint[HINT_W-1] ? '0 : GRP_W'(req_hint);
                     state_in = S_GRP;
                  end
                  OP_FREE, OP_QUERY: begin
                     if (range_bad) begin
                        res_in.status = ST_RANGE;
                        state_in      = S_RESP;
                     end else begin
                        rem_in   = req_num - NUM_W'(1);
                        gidx_in  = '0;
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_GRP: begin
            if ((gidx_ff >= grp_eff) || (ipg_eff == '0)) begin
               res_in.status = ST_FULL;
               state_in      = S_RESP;
            end else begin
               gbase_in  = base_c;
               gend_in   = base_c + FLW'(ipg_eff) - FLW'(1);
               gmul_in   = GM_W'(gidx_ff) * GM_W'(ipg_eff);
               word_in   = base_c[FLW-1:BIT_W];
               ram_raddr = base_c[FLW-1:BIT_W];
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit.found) begin
               ram_we    = 1'b1;
               ram_waddr = word_ff;
               ram_wdata = ram_rdata | (WORD_W'(1) << hit.pos);
               pos_in    = hit.pos;
               state_in  = S_FIN;
            end else if (last_word) begin
               gidx_in  = gidx_ff + GRP_W'(1);
               state_in = S_GRP;
            end else begin
               word_in   = word_ff + AW'(1);
               ram_raddr = word_ff + AW'(1);
            end
         end
         S_FIN: begin
            res_in.alloc  = NUM_W'(gmul_ff + GM_W'(offs_c) + GM_W'(1));
            res_in.status = ST_OK;
            state_in      = S_RESP;
         end
         S_DIV: begin
            // number to group/bit by repeated subtraction of the group size
            if (rem_ff >= NUM_W'(ipg_eff)) begin
               rem_in  = rem_ff - NUM_W'(ipg_eff);
               gidx_in = gidx_ff + GRP_W'(1);
            end else begin
               gbase_in = base_c + FLW'(rem_ff);
               state_in = S_FADR;
            end
         end
         S_FADR: begin
            ram_raddr = gbase_ff[FLW-1:BIT_W];
            word_in   = gbase_ff[FLW-1:BIT_W];
            pos_in    = gbase_ff[BIT_W-1:0];
            state_in  = S_FMOD;
         end
         S_FMOD: begin
            if (op_ff == OP_FREE) begin
               ram_we    = 1'b1;
               ram_waddr = word_ff;
               ram_wdata = ram_rdata & ~(WORD_W'(1) << pos_ff);
            end else begin
               res_in.in_use = ram_rdata[pos_ff];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         ipg_ff       <= IPG_RST;
         grp_ff       <= GRP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_wen) begin
            unique case (csr_addr)
               REG_IPG: ipg_ff <= csr_wdata[IPG_W-1:0];
               REG_GRP: grp_ff <= csr_wdata[GRP_W-1:0];
               default: ;
            endcase
         end
         if ((state_ff == S_RESP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      gidx_ff  <= gidx_in;
      rem_ff   <= rem_in;
      gbase_ff <= gbase_in;
      gend_ff  <= gend_in;
      gmul_ff  <= gmul_in;
      word_ff  <= word_in;
      pos_ff   <= pos_in;
      res_ff   <= res_in;
      if ((state_ff == S_RESP) && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_ff.status, rsp_ff.in_use, rsp_ff.alloc};

endmodule

// ===== rtl/core/ibm_checker.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator checker
// Port-level checks on result fields and transaction sequencing.
// ----------------------------------------------------------------------------
`include "inode_bitmap_allocator_assert.svh"

module ibm_checker import ibm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [NUM_W-1:0] rsp_alloc;
   logic             rsp_use;
   logic [ST_W-1:0]  rsp_status;
   logic             rsp_ok;
   logic             no_alloc;
   logic             rsp_err_v;
   logic             rsp_alloc_v;
   logic             rsp_use_v;
   logic             req_fire;
   logic             rsp_stall;

   assign rsp_alloc   = rsp_tdata[NUM_W-1:0];
   assign rsp_use     = rsp_tdata[RSP_USE_BIT];
   assign rsp_status  = rsp_tdata[RSP_ST_LSB +: ST_W];
   assign rsp_ok      = (rsp_status == ST_OK);
   assign no_alloc    = (rsp_alloc == '0);
   assign rsp_err_v   = rsp_tvalid && !rsp_ok;
   assign rsp_alloc_v = rsp_tvalid && !no_alloc;
   assign rsp_use_v   = rsp_tvalid && rsp_use;
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;

   `IBM_ASSERT_HOLD(a_err_fields, rsp_err_v, no_alloc && !rsp_use, "error result carries data")
   `IBM_ASSERT_HOLD(a_alloc_fields, rsp_alloc_v, rsp_ok && !rsp_use, "allocation result malformed")
   `IBM_ASSERT_HOLD(a_use_fields, rsp_use_v, rsp_ok && no_alloc, "query result malformed")
   `IBM_ASSERT_NEXT(a_one_at_a_time, req_fire, !req_tready, "request taken while busy")
   `IBM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled result moved")

endmodule

bind inode_bitmap_allocator ibm_checker u_ibm_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator regression bench
// A short table of hand-picked transactions opens the run: reset state, field
// extremes, out-of-range numbers, the unused operation, hints past the last
// group, zero and oversized registers and a geometry change over a populated
// bitmap. Random phases follow, each under a fresh geometry. They are weighted
// towards allocate/free/query of live numbers so that small maps fill and
// drain, with a share of junk. Responses are checked against fixed table
// results or an in-bench bitmap predictor, with bursty pacing, patterned stalls.
// ----------------------------------------------------------------------------
module tb;
   import ibm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned MAP_BITS      = MAX_GROUPS_DEF * MAX_PER_GROUP_DEF;
   localparam int unsigned RANDOM_ITEMS  = 1150;
   localparam int unsigned DRAIN_CYCLES  = 600;
   localparam int unsigned IDLE_SETTLE   = 8;
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;
   localparam rsp_type NO_RSP = '0;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_AW-1:0]   idx;
      logic [OP_W-1:0]     op;
      logic [NUM_W-1:0]    num;   // register value on CSR rows
      logic [HINT_W-1:0]   hint;
      bit                  fixed;
      rsp_type             want;
   } plan_row_type;

   localparam plan_row_type OPENING_ROWS [30] = '{
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd1,     5'd0,  1'b1, '{16'd0,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'h1F, 1'b1, '{16'd1,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'd0,  1'b1, '{16'd2,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd1,     5'd0,  1'b1, '{16'd0,     1'b1, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'hFFFF,  5'd15, 1'b1, '{16'd30721, 1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd32768, 5'd0,  1'b1, '{16'd0,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd32769, 5'd0,  1'b1, '{16'd0,     1'b0, ST_RANGE}},
      '{ROW_ITEM, REG_IPG, OP_FREE,   16'd0,     5'd0,  1'b1, '{16'd0,     1'b0, ST_RANGE}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'hFFFF,  5'h1F, 1'b1, '{16'd0,     1'b0, ST_RANGE}},
      '{ROW_ITEM, REG_IPG, OP_UNUSED, 16'hFFFF,  5'h1F, 1'b1, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_FREE,   16'd1,     5'd0,  1'b1, '{16'd0,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd1,     5'd0,  1'b1, '{16'd0,     1'b0, ST_OK}},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'h10, 1'b1, '{16'd1,     1'b0, ST_OK}},
      // oversized registers saturate
      '{ROW_CSR,  REG_IPG, OP_ALLOC,  16'd4095,  5'd0,  1'b0, NO_RSP},
      '{ROW_CSR,  REG_GRP, OP_ALLOC,  16'd31,    5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd32768, 5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'd15, 1'b0, NO_RSP},
      // smaller geometry over a populated map
      '{ROW_CSR,  REG_IPG, OP_ALLOC,  16'd4,     5'd0,  1'b0, NO_RSP},
      '{ROW_CSR,  REG_GRP, OP_ALLOC,  16'd2,     5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'd1,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'd2,  1'b1, '{16'd0,     1'b0, ST_FULL}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd2,     5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd9,     5'd0,  1'b1, '{16'd0,     1'b0, ST_RANGE}},
      // zero registers
      '{ROW_CSR,  REG_IPG, OP_ALLOC,  16'd0,     5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'h1F, 1'b1, '{16'd0,     1'b0, ST_FULL}},
      '{ROW_ITEM, REG_IPG, OP_QUERY,  16'd1,     5'd0,  1'b1, '{16'd0,     1'b0, ST_RANGE}},
      '{ROW_CSR,  REG_IPG, OP_ALLOC,  16'd4,     5'd0,  1'b0, NO_RSP},
      '{ROW_CSR,  REG_GRP, OP_ALLOC,  16'd0,     5'd0,  1'b0, NO_RSP},
      '{ROW_ITEM, REG_IPG, OP_ALLOC,  16'd0,     5'd0,  1'b1, '{16'd0,     1'b0, ST_FULL}},
      '{ROW_ITEM, REG_IPG, OP_FREE,   16'd1,     5'd0,  1'b1, '{16'd0,     1'b0, ST_RANGE}}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [CSR_AW-1:0]      csr_addr   = '0;
   logic [CSR_DW-1:0]      csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // predictor state
   bit                used_bits [MAP_BITS];
   logic [IPG_W-1:0]  ipg_reg = 12'd2048;
   logic [GRP_W-1:0]  grp_reg = 5'd16;

   rsp_type           replies_due [$];
   logic [NUM_W-1:0]  allocated_pool [$];
   int unsigned       mismatch_count = 0;
   longint unsigned   cycle_count = 0;
   int unsigned       burst_left = 0;
   bit                steady_sender = 1'b0;
   logic [15:0]       stall_pattern = '1;
   int unsigned       stall_phase = 0;

   inode_bitmap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic int unsigned eff_ipg();
      return (ipg_reg > MAX_PER_GROUP_DEF) ? MAX_PER_GROUP_DEF : int'(ipg_reg);
   endfunction

   function automatic int unsigned eff_groups();
      return (grp_reg > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : int'(grp_reg);
   endfunction

   // applies one transaction to the bitmap copy and returns its response
   function automatic rsp_type predict_inode_op(input logic [OP_W-1:0] op,
                                                input logic [NUM_W-1:0] num,
                                                input logic [HINT_W-1:0] hint);
      int unsigned ipg, grps, total, start, idx, flat;
      bit          found;
      rsp_type     r;
      ipg   = eff_ipg();
      grps  = eff_groups();
      total = ipg * grps;
      found = 1'b0;
      r     = '0;
      case (op)
         OP_ALLOC: begin
            start = hint[HINT_W-1] ? 0 : int'(hint);
            for (int unsigned g = start; g < grps && !found; g++) begin
               for (int unsigned i = 0; i < ipg && !found; i++) begin
                  if (!used_bits[g * MAX_PER_GROUP_DEF + i]) begin
                     used_bits[g * MAX_PER_GROUP_DEF + i] = 1'b1;
                     r.alloc = NUM_W'(g * ipg + i + 1);
                     found   = 1'b1;
                  end
               end
            end
            if (!found) r.status = ST_FULL;
         end
         OP_FREE, OP_QUERY: begin
            if (num == 0 || num > total || ipg == 0) begin
               r.status = ST_RANGE;
            end else begin
               idx  = num - 1;
               flat = (idx / ipg) * MAX_PER_GROUP_DEF + idx % ipg;
               if (op == OP_FREE) used_bits[flat] = 1'b0;
               else r.in_use = used_bits[flat];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic log_failure(input string why, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected num %0d in_use %0b status %0d,",
                   " got num %0d in_use %0b status %0d"},
                  $realtime, why, want.alloc, want.in_use, want.status,
                  got.alloc, got.in_use, got.status);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == REG_IPG) ipg_reg = val;
      else grp_reg = val[GRP_W-1:0];
      @(posedge clock);
   endtask

   task automatic send_request(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                               input logic [HINT_W-1:0] hint, input bit fixed,
                               input rsp_type want);
      rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - OP_W - NUM_W - HINT_W){1'b0}}, hint, num, op};
      do @(posedge clock); while (!req_tready);
      predicted = predict_inode_op(op, num, hint);
      replies_due.push_back(fixed ? want : predicted);
      if (op == OP_ALLOC && predicted.status == ST_OK) allocated_pool.push_back(predicted.alloc);
   endtask

   task automatic pace();
      int unsigned gap;
      if (steady_sender) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 99) == 0) begin
         wait_idle();
      end else begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response stalls: a rotating 16-bit pattern, reloaded when the phase counter wraps
   always @(posedge clock) begin
      rsp_tready  <= stall_pattern[0];
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase == 63) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.alloc  = rsp_tdata[NUM_W-1:0];
         got.in_use = rsp_tdata[RSP_USE_BIT];
         got.status = rsp_tdata[RSP_ST_LSB +: ST_W];
         if (replies_due.size() == 0) begin
            log_failure("unexpected response", NO_RSP, got);
         end else begin
            want = replies_due.pop_front();
            if (got.alloc !== want.alloc || got.in_use !== want.in_use ||
                got.status !== want.status)
               log_failure("response mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("inode_bitmap_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      plan_row_type      row;
      int unsigned      items_done, phase_len, ipg_pick, grp_pick, total, grps, pick;
      logic [CSR_DW-1:0] grp_word;
      logic [OP_W-1:0]   op;
      logic [NUM_W-1:0]  num;
      logic [HINT_W-1:0] hint;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(OPENING_ROWS); r++) begin
         row = OPENING_ROWS[r];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_reg(row.idx, row.num[CSR_DW-1:0]);
         end else begin
            send_request(row.op, row.num, row.hint, row.fixed, row.want);
            pace();
         end
      end

      items_done = 0;
      while (items_done < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               ipg_pick = MAX_PER_GROUP_DEF;
               grp_pick = MAX_GROUPS_DEF;
            end
            1: begin
               ipg_pick = $urandom_range(MAX_PER_GROUP_DEF + 1, 4095);
               grp_pick = $urandom_range(MAX_GROUPS_DEF + 1, 31);
            end
            2: begin
               ipg_pick = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
               grp_pick = (ipg_pick == 0) ? $urandom_range(0, 31) : 0;
            end
            default: begin
               ipg_pick = $urandom_range(1, 70);
               grp_pick = $urandom_range(1, 4);
            end
         endcase
         wait_idle();
         write_reg(REG_IPG, CSR_DW'(ipg_pick));
         grp_word = CSR_DW'($urandom);
         grp_word[GRP_W-1:0] = GRP_W'(grp_pick);
         write_reg(REG_GRP, grp_word);
         allocated_pool.delete();
         steady_sender = ($urandom_range(0, 3) == 0);
         grps  = eff_groups();
         total = eff_ipg() * grps;
         phase_len = $urandom_range(80, 160);

         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            hint = '0;
            num  = NUM_W'($urandom);
            if (pick < 3) begin
               op   = OP_UNUSED;
               hint = HINT_W'($urandom);
            end else if (pick < 50) begin
               op = OP_ALLOC;
               case ($urandom_range(0, 9))
                  0, 1, 2: hint = HINT_W'($urandom_range(16, 31));
                  8, 9:    hint = HINT_W'($urandom_range(0, 15));
                  default: hint = (grps > 0) ? HINT_W'($urandom_range(0, grps - 1)) : '0;
               endcase
            end else begin
               op = ($urandom_range(0, 1) == 0) ? OP_FREE : OP_QUERY;
               pick = $urandom_range(0, 19);
               if (pick < 10 && allocated_pool.size() != 0) begin
                  pick = $urandom_range(0, allocated_pool.size() - 1);
                  num  = allocated_pool[pick];
                  if (op == OP_FREE) allocated_pool.delete(pick);
               end else if (pick < 17 && total > 0) begin
                  num = NUM_W'($urandom_range(1, total));
               end else if (pick < 18) begin
                  num = '0;
               end else if (pick < 19) begin
                  num = NUM_W'(total + 1);
               end
            end
            send_request(op, num, hint, 1'b0, NO_RSP);
            items_done++;
            if (items_done >= RANDOM_ITEMS) break;
            pace();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (replies_due.size() != 0) log_failure("response missing", replies_due.pop_front(), NO_RSP);
      if (mismatch_count == 0) begin
         $display("inode_bitmap_allocator regression: pass");
      end else begin
         $display("inode_bitmap_allocator regression: fail");
      end
      $finish;
   end

endmodule
